### rtl/sdfae_pkg.sv
// shared types and constants for the arc firing expansion block
package sdfae_pkg;

   // largest repetition count that still gives a valid arc
   localparam int MAX_REPETITIONS = 32;

   // shift-subtract divider geometry
   localparam int DIVIDEND_W = 16;
   localparam int DIVISOR_W  = 14;
   localparam int DIV_CNT_W  = 4;

   // stream payload widths, padded to whole bytes
   localparam int REQ_W = 48;
   localparam int RSP_W = 56;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_A,
      ST_LOAD_B,
      ST_DIV_B,
      ST_INIT,
      ST_WALK
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic emit_bad;
      logic div_load_a;
      logic div_load_b;
      logic div_step;
      logic walk_init;
      logic emit_link;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic bad;
      logic div_last;
      logic walk_done;
      logic out_free;
   } status_type;

endpackage

### rtl/sdfae_ctrl.sv
// sequencing controller for the arc firing expansion block
module sdfae_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  sdfae_pkg::status_type  status,
   output sdfae_pkg::cmd_type     cmd
);
   import sdfae_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!status.bad) state_in = ST_DIV_A;
            else if (status.out_free) state_in = ST_IDLE;
         end
         ST_DIV_A: begin
            if (status.div_last) state_in = ST_LOAD_B;
         end
         ST_LOAD_B: state_in = ST_DIV_B;
         ST_DIV_B: begin
            if (status.div_last) state_in = ST_INIT;
         end
         ST_INIT: state_in = ST_WALK;
         ST_WALK: begin
            if (status.out_free && status.walk_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_CHECK: begin
            cmd.emit_bad   = status.bad && status.out_free;
            cmd.div_load_a = !status.bad;
         end
         ST_DIV_A:  cmd.div_step   = 1'b1;
         ST_LOAD_B: cmd.div_load_b = 1'b1;
         ST_DIV_B:  cmd.div_step   = 1'b1;
         ST_INIT:   cmd.walk_init  = 1'b1;
         ST_WALK:   cmd.emit_link  = status.out_free;
         default: begin
            cmd        = '0;
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

### rtl/sdfae_dp.sv
// datapath: operand registers, shared divider, token walk and result register
module sdfae_dp #(
   parameter int MAX_LINKS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sdfae_pkg::cmd_type            cmd,
   output sdfae_pkg::status_type         status,
   input  logic [sdfae_pkg::REQ_W-1:0]   req_tdata,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [sdfae_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                          rsp_tlast,
   output logic                          rsp_tuser
);
   import sdfae_pkg::*;

   localparam int LINK_W = $clog2(MAX_LINKS + 1);

   // arc descriptor
   logic [7:0]  p_ff, q_ff;
   logic [15:0] d_ff;
   logic [5:0]  vs_ff, vd_ff;

   // divider
   logic [DIVISOR_W-1:0]  total_ff, total_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0]  dcnt_ff, dcnt_in;

   // walk state
   logic [7:0]         s_smp_ff, s_smp_in, d_smp_ff, d_smp_in;
   logic [5:0]         s_inv_ff, s_inv_in, d_inv_ff, d_inv_in;
   logic [15:0]        dly_ff, dly_in;
   logic signed [14:0] left_ff, left_in;
   logic [LINK_W-1:0]  n_ff, n_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [5:0]  out_sf_ff, out_sf_in, out_df_ff, out_df_in;
   logic [7:0]  out_cnt_ff, out_cnt_in;
   logic [15:0] out_dly_ff, out_dly_in;
   logic [7:0]  out_si_ff, out_si_in, out_di_ff, out_di_in;
   logic        out_last_ff, out_last_in, out_err_ff, out_err_in;

   // combinational helpers
   logic [DIVISOR_W-1:0]  prod;
   logic [DIVISOR_W:0]    shifted, diff;
   logic                  fits;
   logic signed [9:0]     test;
   logic [7:0]            cnt;
   logic signed [14:0]    left_next;
   logic [LINK_W-1:0]     n_next;
   logic                  exhausted, over, walk_err;
   logic [5:0]            s_inv_step, d_inv_step;

   // degenerate arc check
   assign status.bad = (p_ff == 8'd0) || (q_ff == 8'd0) || (vs_ff == 6'd0) ||
                       (vd_ff == 6'd0) ||
                       ({3'b000, vs_ff} > 9'(MAX_REPETITIONS)) ||
                       ({3'b000, vd_ff} > 9'(MAX_REPETITIONS));

   // tokens per period at the sink end
   assign prod = {8'd0, vd_ff} * {6'd0, q_ff};

   // one restoring division step
   assign shifted = {rem_ff, dvd_ff[DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = ~diff[DIVISOR_W];
   assign status.div_last = (dcnt_ff == DIV_CNT_W'(DIVIDEND_W - 1));

   // link arithmetic on the current boundary
   assign test = $signed({2'b00, p_ff}) - $signed({2'b00, s_smp_ff})
               - $signed({2'b00, q_ff}) + $signed({2'b00, d_smp_ff});
   assign cnt  = (test <= 10'sd0) ? (p_ff - s_smp_ff + 8'd1) : (q_ff - d_smp_ff + 8'd1);
   assign left_next = left_ff - $signed({7'd0, cnt});
   assign n_next    = n_ff + LINK_W'(1);
   assign exhausted = (left_next <= 15'sd0);
   assign over      = (n_next >= LINK_W'(MAX_LINKS));
   assign walk_err  = (left_next < 15'sd0) || (!exhausted && over);
   assign status.walk_done = exhausted || over;
   assign s_inv_step = s_inv_ff + 6'd1;
   assign d_inv_step = d_inv_ff + 6'd1;

   assign status.out_free = !out_valid_ff || rsp_tready;

   // next values of the datapath registers
   always_comb begin
      total_in = total_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      dcnt_in  = dcnt_ff;
      s_smp_in = s_smp_ff;
      d_smp_in = d_smp_ff;
      s_inv_in = s_inv_ff;
      d_inv_in = d_inv_ff;
      dly_in   = dly_ff;
      left_in  = left_ff;
      n_in     = n_ff;

      if (cmd.div_load_a) begin
         total_in = prod;
         dvs_in   = prod;
         dvd_in   = d_ff;
         rem_in   = '0;
         dcnt_in  = '0;
      end

      if (cmd.div_step) begin
         rem_in  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         dvd_in  = {dvd_ff[DIVIDEND_W-2:0], fits};
         dcnt_in = dcnt_ff + DIV_CNT_W'(1);
      end

      // whole periods kept, offset into the period divided by q
      if (cmd.div_load_b) begin
         dly_in  = dvd_ff;
         dvd_in  = {{(DIVIDEND_W - DIVISOR_W){1'b0}}, rem_ff};
         rem_in  = '0;
         dvs_in  = {{(DIVISOR_W - 8){1'b0}}, q_ff};
         dcnt_in = '0;
      end

      if (cmd.walk_init) begin
         s_smp_in = 8'd1;
         s_inv_in = 6'd1;
         d_smp_in = rem_ff[7:0] + 8'd1;
         d_inv_in = dvd_ff[5:0] + 6'd1;
         left_in  = $signed({1'b0, total_ff});
         n_in     = '0;
      end

      // step to the next token boundary
      if (cmd.emit_link) begin
         left_in = left_next;
         n_in    = n_next;
         if (test == 10'sd0) begin
            s_smp_in = 8'd1;
            d_smp_in = 8'd1;
            s_inv_in = s_inv_step;
            d_inv_in = d_inv_step;
         end else if (test < 10'sd0) begin
            s_smp_in = 8'd1;
            d_smp_in = d_smp_ff + cnt;
            s_inv_in = s_inv_step;
         end else begin
            d_smp_in = 8'd1;
            s_smp_in = s_smp_ff + cnt;
            d_inv_in = d_inv_step;
         end
         if (s_inv_in > vs_ff) s_inv_in = 6'd1;
         if (d_inv_in > vd_ff) begin
            d_inv_in = 6'd1;
            if (dly_ff != 16'hFFFF) dly_in = dly_ff + 16'd1;
         end
      end
   end

   // next values of the result register
   always_comb begin
      out_sf_in   = out_sf_ff;
      out_df_in   = out_df_ff;
      out_cnt_in  = out_cnt_ff;
      out_dly_in  = out_dly_ff;
      out_si_in   = out_si_ff;
      out_di_in   = out_di_ff;
      out_last_in = out_last_ff;
      out_err_in  = out_err_ff;
      out_valid_in = rsp_tready ? 1'b0 : out_valid_ff;

      if (cmd.emit_bad) begin
         out_valid_in = 1'b1;
         out_sf_in    = '0;
         out_df_in    = '0;
         out_cnt_in   = '0;
         out_dly_in   = '0;
         out_si_in    = '0;
         out_di_in    = '0;
         out_last_in  = 1'b1;
         out_err_in   = 1'b1;
      end else if (cmd.emit_link) begin
         out_valid_in = 1'b1;
         out_sf_in    = s_inv_ff;
         out_df_in    = d_inv_ff;
         out_cnt_in   = cnt;
         out_dly_in   = dly_ff;
         out_si_in    = s_smp_ff;
         out_di_in    = d_smp_ff;
         out_last_in  = status.walk_done;
         out_err_in   = walk_err;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // descriptor capture on an input transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         p_ff  <= req_tdata[7:0];
         q_ff  <= req_tdata[15:8];
         d_ff  <= req_tdata[31:16];
         vs_ff <= req_tdata[37:32];
         vd_ff <= req_tdata[43:38];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      total_ff    <= total_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      dcnt_ff     <= dcnt_in;
      s_smp_ff    <= s_smp_in;
      d_smp_ff    <= d_smp_in;
      s_inv_ff    <= s_inv_in;
      d_inv_ff    <= d_inv_in;
      dly_ff      <= dly_in;
      left_ff     <= left_in;
      n_ff        <= n_in;
      out_sf_ff   <= out_sf_in;
      out_df_ff   <= out_df_in;
      out_cnt_ff  <= out_cnt_in;
      out_dly_ff  <= out_dly_in;
      out_si_ff   <= out_si_in;
      out_di_ff   <= out_di_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   // result channel
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_di_ff, out_si_ff, out_dly_ff,
                        out_cnt_ff, out_df_ff, out_sf_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;

endmodule

### rtl/sdf_arc_firing_expansion.sv
// top level of the dataflow arc firing expansion block
//
// One transfer on the req_ channel carries one arc descriptor: rates at both
// ends, initial delay tokens and the repetition counts. The block answers on
// the rsp_ channel with a run of firing-to-firing links; rsp_tlast marks the
// final link and rsp_tuser flags a rate error (inconsistent rates, overshoot
// or a run cut off at MAX_LINKS links). A degenerate arc gives one link with
// all fields zero, tlast and tuser set.
// Sequence: the descriptor is checked, then two 16-step shift-subtract
// divisions run on one shared divider (period delay and start offset), then
// the walk gives one link per cycle while the result register is free.
// The result register holds a link while rsp_tready is low and the walk
// pauses; a new descriptor is taken as soon as the last link sits in the
// result register, even if it has not been taken yet.
// Reset (synchronous, active high) empties the result register and returns
// the controller to idle; no clearing pass is needed.
module sdf_arc_firing_expansion #(
   parameter int MAX_LINKS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // produced_per_firing, consumed_per_firing, initial_delay,
   // src_repetitions, dest_repetitions
   input  logic [sdfae_pkg::REQ_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // src_firing, dest_firing, token_count, period_delay,
   // src_token_index, dest_token_index
   output logic [sdfae_pkg::RSP_W-1:0] rsp_tdata,
   output logic                        rsp_tlast,
   // rate_error
   output logic                        rsp_tuser
);
   import sdfae_pkg::*;

   cmd_type    cmd;
   status_type status;

   // controller
   sdfae_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath
   sdfae_dp #(
      .MAX_LINKS (MAX_LINKS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
